### design/salru_pkg.sv
// Shared types and constants for the set-associative LRU cache model.
// No dependencies; imported by the lookup unit and the top level.
`default_nettype none

package salru_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int COUNT_BITS   = 32;

    localparam int ADDR_BITS    = 64;
    localparam int TAG_BITS     = 64;
    localparam int SET_BITS     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int SET_COUNT    = 1 << MAX_SET_BITS;
    localparam int WAY_BITS     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_CNT_BITS = $clog2(MAX_WAYS + 1);

    typedef logic [TAG_BITS-1:0]     t_tag;
    typedef logic [WAY_BITS-1:0]     t_rank;
    typedef logic [SET_BITS-1:0]     t_set;
    typedef logic [WAY_CNT_BITS-1:0] t_ways;
    typedef logic [COUNT_BITS-1:0]   t_count;

    localparam t_rank RANK_TOP = WAY_BITS'(MAX_WAYS - 1);

    // Access kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_STORE  = 2'd1;
    localparam logic [1:0] KIND_MODIFY = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [1:0] CFG_WAY_COUNT   = 2'd1;
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd2;

    // One memory row holds every way of one set.
    typedef struct packed {
        logic [MAX_WAYS-1:0]           valid;
        logic [MAX_WAYS-1:0][WAY_BITS-1:0] rank;
        logic [MAX_WAYS-1:0][TAG_BITS-1:0] tag;
    } t_row;

    localparam int ROW_BITS = $bits(t_row);

    // Outcome of one lookup, from the lookup unit to the top level.
    typedef struct packed {
        logic we;
        logic hit;
        logic miss;
        logic evict;
        logic modify;
    } t_look;

endpackage

`default_nettype wire

### design/salru_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module salru_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### design/salru_lookup.sv
// Tag compare, victim choice and LRU rank update for one set row.
// Depends on salru_pkg.
`default_nettype none

module salru_lookup (
    input  wire salru_pkg::t_row  i_row,
    input  wire logic             i_live,
    input  wire salru_pkg::t_tag  i_tag,
    input  wire salru_pkg::t_ways i_ways,
    input  wire logic [1:0]       i_kind,
    output salru_pkg::t_row       o_row,
    output salru_pkg::t_look      o_look
);

    import salru_pkg::*;

    logic [MAX_WAYS-1:0]               w_in_use;
    logic [MAX_WAYS-1:0]               w_valid;
    logic [MAX_WAYS-1:0]               w_match;
    logic [MAX_WAYS-1:0]               w_free;
    logic [MAX_WAYS-1:0][WAY_BITS-1:0] w_rank;
    logic [WAY_BITS-1:0]               w_found;
    logic [WAY_BITS-1:0]               w_empty;
    logic [WAY_BITS-1:0]               w_victim;
    logic [WAY_BITS-1:0]               w_target;
    t_rank                             w_old;
    logic                              w_is_hit;
    logic                              w_has_free;
    logic                              w_kind_ok;

    always_comb begin
        // A row never written reads as all invalid with rank zero.
        for (int i = 0; i < MAX_WAYS; i++) begin
            w_in_use[i] = (i < int'(i_ways));
            w_valid[i]  = i_live & i_row.valid[i];
            w_rank[i]   = i_live ? i_row.rank[i] : '0;
            w_match[i]  = w_in_use[i] & w_valid[i] & (i_row.tag[i] == i_tag);
            w_free[i]   = w_in_use[i] & ~w_valid[i];
        end

        // Lowest matching way and lowest empty way.
        w_found = '0;
        w_empty = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_found = WAY_BITS'(i);
            end
            if (w_free[i]) begin
                w_empty = WAY_BITS'(i);
            end
        end

        // Oldest way, lowest index on ties.
        w_victim = '0;
        for (int i = 1; i < MAX_WAYS; i++) begin
            if (w_in_use[i] && (w_rank[i] > w_rank[w_victim])) begin
                w_victim = WAY_BITS'(i);
            end
        end

        w_is_hit   = |w_match;
        w_has_free = |w_free;
        w_kind_ok  = (i_kind == KIND_LOAD) || (i_kind == KIND_STORE) ||
                     (i_kind == KIND_MODIFY);
        w_target   = w_is_hit ? w_found : (w_has_free ? w_empty : w_victim);
        w_old      = w_rank[w_found];

        o_row.valid = w_valid;
        o_row.rank  = w_rank;
        o_row.tag   = i_row.tag;

        // On a hit, age every other valid way younger than the touched one; on a miss, every other valid way.
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (w_in_use[i] && (WAY_BITS'(i) != w_target) && w_valid[i] &&
                (!w_is_hit || (w_rank[i] < w_old)) && (w_rank[i] < RANK_TOP)) begin
                o_row.rank[i] = w_rank[i] + 1'b1;
            end
        end
        o_row.rank[w_target] = '0;
        if (!w_is_hit) begin
            o_row.valid[w_target] = 1'b1;
            o_row.tag[w_target]   = i_tag;
        end

        o_look.we     = w_kind_ok;
        o_look.hit    = w_kind_ok & w_is_hit;
        o_look.miss   = w_kind_ok & ~w_is_hit;
        o_look.evict  = w_kind_ok & ~w_is_hit & ~w_has_free;
        o_look.modify = (i_kind == KIND_MODIFY);
    end

endmodule

`default_nettype wire

### design/set_associative_cache_lru_sim.sv
// A result is registered at the edge that ends the lookup state, which an accepted
// access beat enters from the idle state, unless an earlier result still waits.
// One access is handled at a time: accepting it reads the set row from the row
// memory, and the lookup state compares tags and writes the updated row back.
// A result not yet taken holds the lookup state until the output frees.
// Reset (synchronous, active low) clears control, config, totals and the
// per-set row flags at once; no clearing pass runs over the row memory.
`default_nettype none

module set_associative_cache_lru_sim (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration write port
    input  wire logic                      i_cfg_we,
    input  wire logic [1:0]                i_cfg_idx,
    input  wire logic [5:0]                i_cfg_data,
    // access channel
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [1:0]                i_access_kind,
    input  wire logic [salru_pkg::ADDR_BITS-1:0] i_address,
    // result channel
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic                           o_access_hit,
    output logic                           o_access_miss,
    output logic                           o_access_eviction,
    output logic                           o_modify_hit,
    output logic [31:0]                    o_total_hits,
    output logic [31:0]                    o_total_misses,
    output logic [31:0]                    o_total_evictions
);

    import salru_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_LOOK
    } t_state;

    // Configuration registers
    logic [2:0]    r_cfg_set_bits;
    logic [3:0]    r_cfg_ways;
    logic [5:0]    r_cfg_offset;

    // Control and latched access
    t_state        r_state;
    logic [1:0]    r_kind;
    t_tag          r_tag;
    t_set          r_set;
    t_ways         r_ways;
    logic          r_live;
    logic [SET_COUNT-1:0] r_row_live;

    // Totals and result register
    t_count        r_hits;
    t_count        r_misses;
    t_count        r_evicts;
    logic          r_out_valid;
    logic          r_out_hit;
    logic          r_out_miss;
    logic          r_out_evict;
    logic          r_out_modify;

    logic          w_accept;
    logic          w_done;
    logic [2:0]    w_s_eff;
    t_ways         w_ways_eff;
    logic [6:0]    w_shift;
    t_tag          w_tag;
    logic [ADDR_BITS-1:0] w_set_wide;
    logic [SET_BITS:0]    w_set_mask;
    t_set          w_set;
    logic [ROW_BITS-1:0]  w_rd_data;
    t_row          w_rd_row;
    t_row          w_new_row;
    t_look         w_look;
    t_count        n_hits;
    t_count        n_misses;
    t_count        n_evicts;

    function automatic t_count sat_add(input t_count a, input logic [1:0] inc);
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, a} + (COUNT_BITS + 1)'(inc);
        return sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
    endfunction

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    // Finish the lookup only when the result register can take the beat.
    assign w_done   = (r_state == S_LOOK) && (!r_out_valid || i_ready);

    // Clamp the configured geometry.
    always_comb begin
        w_s_eff = (int'(r_cfg_set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : r_cfg_set_bits;
        if (r_cfg_ways == 4'd0) begin
            w_ways_eff = WAY_CNT_BITS'(1);
        end else if (int'(r_cfg_ways) > MAX_WAYS) begin
            w_ways_eff = WAY_CNT_BITS'(MAX_WAYS);
        end else begin
            w_ways_eff = WAY_CNT_BITS'(r_cfg_ways);
        end
    end

    // Split the address into set index and tag.
    assign w_shift    = 7'(w_s_eff) + 7'(r_cfg_offset);
    assign w_tag      = (w_shift >= 7'd64) ? '0 : (i_address >> w_shift);
    assign w_set_wide = i_address >> r_cfg_offset;
    assign w_set_mask = ((SET_BITS + 1)'(1) << w_s_eff) - 1'b1;
    assign w_set      = w_set_wide[SET_BITS-1:0] & w_set_mask[SET_BITS-1:0];

    salru_ram #(
        .ADDR_W (SET_BITS),
        .DATA_W (ROW_BITS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (w_done && w_look.we),
        .i_waddr (r_set),
        .i_wdata (w_new_row),
        .i_re    (w_accept),
        .i_raddr (w_set),
        .o_rdata (w_rd_data)
    );

    assign w_rd_row = t_row'(w_rd_data);

    salru_lookup u_lookup (
        .i_row  (w_rd_row),
        .i_live (r_live),
        .i_tag  (r_tag),
        .i_ways (r_ways),
        .i_kind (r_kind),
        .o_row  (w_new_row),
        .o_look (w_look)
    );

    // A modify bumps the hit total once more for its store half, on a miss as well.
    assign n_hits   = sat_add(r_hits, 2'(w_look.hit) + 2'(w_look.modify));
    assign n_misses = sat_add(r_misses, 2'(w_look.miss));
    assign n_evicts = sat_add(r_evicts, 2'(w_look.evict));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_set_bits <= 3'd0;
            r_cfg_ways     <= 4'd1;
            r_cfg_offset   <= 6'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SET_BITS:    r_cfg_set_bits <= i_cfg_data[2:0];
                CFG_WAY_COUNT:   r_cfg_ways     <= i_cfg_data[3:0];
                CFG_OFFSET_BITS: r_cfg_offset   <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // Latch the access while its set row is read.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_access_kind;
            r_tag  <= w_tag;
            r_set  <= w_set;
            r_ways <= w_ways_eff;
            r_live <= r_row_live[w_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_live  <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the taken beat unless a new one replaces it this cycle.
            if (r_out_valid && i_ready && !w_done) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (w_done) begin
                        if (w_look.we) begin
                            r_row_live[r_set] <= 1'b1;
                        end
                        r_hits       <= n_hits;
                        r_misses     <= n_misses;
                        r_evicts     <= n_evicts;
                        r_out_valid  <= 1'b1;
                        r_out_hit    <= w_look.hit;
                        r_out_miss   <= w_look.miss;
                        r_out_evict  <= w_look.evict;
                        r_out_modify <= w_look.modify;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid           = r_out_valid;
    assign o_access_hit      = r_out_hit;
    assign o_access_miss     = r_out_miss;
    assign o_access_eviction = r_out_evict;
    assign o_modify_hit      = r_out_modify;
    assign o_total_hits      = 32'(r_hits);
    assign o_total_misses    = 32'(r_misses);
    assign o_total_evictions = 32'(r_evicts);

`ifndef SYNTH
    // An accepted beat always occupies the lookup cycle next.
    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_LOOK))
        else $error("accepted access did not enter lookup");

    // The row memory is written only while finishing a lookup.
    a_write_in_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && w_look.we) |-> (r_state == S_LOOK) && (!r_out_valid || i_ready))
        else $error("row write outside lookup completion");

    // Hit and miss are exclusive on every result.
    a_hit_miss_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_access_hit && o_access_miss))
        else $error("result flags both hit and miss");

    // An eviction is always a miss.
    a_evict_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_access_eviction) |-> o_access_miss)
        else $error("eviction without miss");

    // Totals never decrease.
    a_totals_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> (r_hits >= $past(r_hits)) && (r_misses >= $past(r_misses)) &&
                   (r_evicts >= $past(r_evicts)))
        else $error("running total decreased");
`endif

endmodule

`default_nettype wire
